// File: design/ptmr_pkg.sv
`default_nettype none
package ptmr_pkg;

  localparam int DATA_W       = 32;
  localparam int PRESCALE_W   = 8;
  localparam int DIV_SEL_W    = 3;
  localparam int DIV_CNT_W    = 4;
  localparam int CMD_W        = 2;
  localparam int SEL_W        = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = PRESCALE_W;
  localparam int COUNT_W_DEF  = 32;

  // Largest divider select that still means something (1/16)
  localparam logic [DIV_SEL_W-1:0] DIV_SEL_MAX = DIV_SEL_W'(4);

  // Bus bit positions
  localparam int BIT_START   = 12;
  localparam int BIT_UPDATE  = 13;
  localparam int BIT_RELOAD  = 15;
  localparam int BIT_IRQ_EN  = 2;
  localparam int BIT_IRQ_PND = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } command_t;

  typedef enum logic [SEL_W-1:0] {
    SEL_CONTROL = 2'd0,
    SEL_BUFFER  = 2'd1,
    SEL_OBSERVE = 2'd2,
    SEL_IRQ     = 2'd3
  } reg_sel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE = 1'b0,
    CFG_DIVIDER  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic start;
    logic update;
    logic reload;
  } control_t;

endpackage
`default_nettype wire

// File: design/ptmr_in_if.sv
`default_nettype none
interface ptmr_in_if
  import ptmr_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [SEL_W-1:0] reg_select;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output command, output reg_select, output write_data,
                  input ready);
  modport sink (input valid, input command, input reg_select, input write_data,
                output ready);
endinterface
`default_nettype wire

// File: design/ptmr_out_if.sv
`default_nettype none
interface ptmr_out_if
  import ptmr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq;

  modport source (output valid, output read_data, output irq, input ready);
  modport sink (input valid, input read_data, input irq, output ready);
endinterface
`default_nettype wire

// File: design/prescaled_down_count_timer_top.sv
`default_nettype none
// One down-count timer channel behind a small register file. Each input item
// is a register read, a register write, one input clock tick or a no-op; every
// item returns exactly one result item (read data, zero for anything but a read,
// and the interrupt line after the item). Ticks pass a prescaler that divides by
// prescale_value + 1 and a power-of-two divider (1/1 .. 1/16, selects above four
// act as 1/16); each divided tick counts the channel down while started, or
// reloads it while update is set. Reaching zero (from one or zero) sets the
// write-one-to-clear pending bit and either reloads from the count buffer
// (auto-reload) or stops. Rate: one item per clock while results are taken.
// All timer state is updated in the cycle an item is taken, and the result
// lands in a single output register; input ready is high whenever that register
// is empty or being drained in the same cycle, so a stall on the result side
// holds the input for exactly as long. The configuration port (prescale value,
// divider select) is written with cfg_we and takes effect on the next tick item.
module prescaled_down_count_timer_top
  import ptmr_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  ptmr_in_if.sink                    in_ch,
  ptmr_out_if.source                 out_ch
);

  // Configuration registers
  logic [PRESCALE_W-1:0] prescale_value;
  logic [DIV_SEL_W-1:0]  divider_select;

  // Timer state
  logic [PRESCALE_W-1:0]  prescale_count, prescale_count_next;
  logic [DIV_CNT_W-1:0]   divide_count, divide_count_next;
  logic [COUNT_WIDTH-1:0] down_counter, down_counter_next;
  logic [COUNT_WIDTH-1:0] reload_buffer, reload_buffer_next;
  control_t               control, control_next;
  logic                   irq_enable, irq_enable_next;
  logic                   irq_pending, irq_pending_next;

  // Result register
  logic              out_valid;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic              out_irq;

  logic     accept;
  command_t cmd;
  reg_sel_t sel;

  // Tick path
  logic [DIV_SEL_W-1:0] div_sel;
  logic [DIV_CNT_W-1:0] div_last;
  logic                 ps_wrap;
  logic                 div_wrap;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = command_t'(in_ch.command);
  assign sel         = reg_sel_t'(in_ch.reg_select);

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_value <= '0;
      divider_select <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRESCALE: prescale_value <= cfg_wdata[PRESCALE_W-1:0];
        CFG_DIVIDER:  divider_select <= cfg_wdata[DIV_SEL_W-1:0];
        default:      ;
      endcase
    end
  end

  // Clamp divider select and form the terminal count of the divider
  assign div_sel  = (divider_select > DIV_SEL_MAX) ? DIV_SEL_MAX : divider_select;
  assign div_last = DIV_CNT_W'((1 << div_sel) - 1);
  assign ps_wrap  = prescale_count >= prescale_value;
  assign div_wrap = divide_count >= div_last;

  always_comb begin
    prescale_count_next = prescale_count;
    divide_count_next   = divide_count;
    down_counter_next   = down_counter;
    reload_buffer_next  = reload_buffer;
    control_next        = control;
    irq_enable_next     = irq_enable;
    irq_pending_next    = irq_pending;
    out_data_next       = '0;

    unique case (cmd)
      CMD_READ: begin
        unique case (sel)
          SEL_CONTROL: begin
            out_data_next[BIT_START]  = control.start;
            out_data_next[BIT_UPDATE] = control.update;
            out_data_next[BIT_RELOAD] = control.reload;
          end
          SEL_BUFFER:  out_data_next = DATA_W'(reload_buffer);
          SEL_OBSERVE: out_data_next = DATA_W'(down_counter);
          SEL_IRQ: begin
            out_data_next[BIT_IRQ_EN]  = irq_enable;
            out_data_next[BIT_IRQ_PND] = irq_pending;
          end
          default: ;
        endcase
      end
      CMD_WRITE: begin
        unique case (sel)
          SEL_CONTROL: begin
            control_next.start  = in_ch.write_data[BIT_START];
            control_next.update = in_ch.write_data[BIT_UPDATE];
            control_next.reload = in_ch.write_data[BIT_RELOAD];
            // Manual update loads the counter at once
            if (in_ch.write_data[BIT_UPDATE]) down_counter_next = reload_buffer;
          end
          SEL_BUFFER:  reload_buffer_next = in_ch.write_data[COUNT_WIDTH-1:0];
          SEL_OBSERVE: ;
          SEL_IRQ: begin
            irq_enable_next = in_ch.write_data[BIT_IRQ_EN];
            if (in_ch.write_data[BIT_IRQ_PND]) irq_pending_next = 1'b0;
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (!ps_wrap) begin
          prescale_count_next = prescale_count + PRESCALE_W'(1);
        end else begin
          prescale_count_next = '0;
          if (!div_wrap) begin
            divide_count_next = divide_count + DIV_CNT_W'(1);
          end else begin
            divide_count_next = '0;
            // Divided tick: count, reload or expire
            if (control.start) begin
              if (control.update) begin
                down_counter_next = reload_buffer;
              end else if (down_counter <= COUNT_WIDTH'(1)) begin
                irq_pending_next = 1'b1;
                if (control.reload) begin
                  down_counter_next = reload_buffer;
                end else begin
                  down_counter_next  = '0;
                  control_next.start = 1'b0;
                end
              end else begin
                down_counter_next = down_counter - COUNT_WIDTH'(1);
              end
            end
          end
        end
      end
      CMD_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      divide_count   <= '0;
      down_counter   <= '0;
      reload_buffer  <= '0;
      control        <= '0;
      irq_enable     <= 1'b0;
      irq_pending    <= 1'b0;
    end else if (accept) begin
      prescale_count <= prescale_count_next;
      divide_count   <= divide_count_next;
      down_counter   <= down_counter_next;
      reload_buffer  <= reload_buffer_next;
      control        <= control_next;
      irq_enable     <= irq_enable_next;
      irq_pending    <= irq_pending_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
      out_irq  <= irq_enable_next && irq_pending_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.read_data = out_data;
  assign out_ch.irq       = out_irq;

`ifndef ASSERT_OFF
  // The held interrupt always matches the state it was computed from
  a_irq_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_irq == (irq_enable && irq_pending)))
    else $error("result irq disagrees with interrupt state");

  // The counter moves only on an accepted item
  a_counter_quiet: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(accept)) |-> $stable(down_counter))
    else $error("down counter changed without an item");

  // Start drops only on a tick (expiry) or a control write
  a_start_fall: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(control.start)) |->
      $past(accept && (cmd == CMD_TICK || (cmd == CMD_WRITE && sel == SEL_CONTROL))))
    else $error("start cleared without a cause");
`endif

endmodule
`default_nettype wire

// File: verif/tb_prescaled_down_count_timer_top.sv
`timescale 1ns / 1ps
module tb_prescaled_down_count_timer_top
  import ptmr_pkg::*;
;

  // Bus masks for the control and interrupt registers
  localparam logic [DATA_W-1:0] CTRL_START   = DATA_W'(1) << BIT_START;
  localparam logic [DATA_W-1:0] CTRL_UPDATE  = DATA_W'(1) << BIT_UPDATE;
  localparam logic [DATA_W-1:0] CTRL_RELOAD  = DATA_W'(1) << BIT_RELOAD;
  localparam logic [DATA_W-1:0] IRQ_EN_MASK  = DATA_W'(1) << BIT_IRQ_EN;
  localparam logic [DATA_W-1:0] IRQ_PND_MASK = DATA_W'(1) << BIT_IRQ_PND;
  // Counter width of the instance (default parameter)
  localparam logic [DATA_W-1:0] COUNT_MASK   = {DATA_W{1'b1}} >> (DATA_W - COUNT_W_DEF);

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_LIMIT     = 5000;

  // Shadow copy of the timer channel plus the queue of results it still owes.
  class timer_shadow;
    logic [PRESCALE_W-1:0] prescale_value;
    logic [DIV_SEL_W-1:0]  divider_select;
    logic [PRESCALE_W-1:0] prescale_count;
    logic [DIV_CNT_W-1:0]  divide_count;
    logic [DATA_W-1:0]     down_counter;
    logic [DATA_W-1:0]     reload_buffer;
    control_t              ctrl;
    logic                  irq_enable;
    logic                  irq_pending;
    logic [DATA_W-1:0]     due_read_data[$];
    logic                  due_irq[$];
    int unsigned           errors;

    function new();
      prescale_value = '0;
      divider_select = '0;
      prescale_count = '0;
      divide_count   = '0;
      down_counter   = '0;
      reload_buffer  = '0;
      ctrl           = '0;
      irq_enable     = 1'b0;
      irq_pending    = 1'b0;
      errors         = 0;
    endfunction

    function void set_config(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_PRESCALE) begin
        prescale_value = value;
      end else begin
        divider_select = value[DIV_SEL_W-1:0];
      end
    endfunction

    // Advance the shadow by one accepted item and queue the result it owes.
    function void take_item(command_t cmd, reg_sel_t sel, logic [DATA_W-1:0] data);
      logic [DATA_W-1:0]    rd;
      logic [DIV_SEL_W-1:0] eff_sel;
      logic [DIV_CNT_W-1:0] last_phase;
      rd = '0;
      case (cmd)
        CMD_READ: begin
          case (sel)
            SEL_CONTROL: begin
              rd[BIT_START]  = ctrl.start;
              rd[BIT_UPDATE] = ctrl.update;
              rd[BIT_RELOAD] = ctrl.reload;
            end
            SEL_BUFFER:  rd = reload_buffer;
            SEL_OBSERVE: rd = down_counter;
            default: begin
              rd[BIT_IRQ_EN]  = irq_enable;
              rd[BIT_IRQ_PND] = irq_pending;
            end
          endcase
        end
        CMD_WRITE: begin
          case (sel)
            SEL_CONTROL: begin
              ctrl.start  = data[BIT_START];
              ctrl.update = data[BIT_UPDATE];
              ctrl.reload = data[BIT_RELOAD];
              if (ctrl.update) down_counter = reload_buffer;
            end
            SEL_BUFFER:  reload_buffer = data & COUNT_MASK;
            SEL_OBSERVE: ;
            default: begin
              irq_enable = data[BIT_IRQ_EN];
              if (data[BIT_IRQ_PND]) irq_pending = 1'b0;
            end
          endcase
        end
        CMD_TICK: begin
          eff_sel    = (divider_select > DIV_SEL_MAX) ? DIV_SEL_MAX : divider_select;
          last_phase = DIV_CNT_W'((1 << eff_sel) - 1);
          if (prescale_count < prescale_value) begin
            prescale_count = prescale_count + 1'b1;
          end else begin
            prescale_count = '0;
            if (divide_count < last_phase) begin
              divide_count = divide_count + 1'b1;
            end else begin
              divide_count = '0;
              if (ctrl.start) begin
                if (ctrl.update) begin
                  down_counter = reload_buffer;
                end else if (down_counter <= 1) begin
                  irq_pending = 1'b1;
                  if (ctrl.reload) begin
                    down_counter = reload_buffer;
                  end else begin
                    down_counter = '0;
                    ctrl.start   = 1'b0;
                  end
                end else begin
                  down_counter = (down_counter - 1'b1) & COUNT_MASK;
                end
              end
            end
          end
        end
        default: ;
      endcase
      due_read_data.push_back(rd);
      due_irq.push_back(irq_enable & irq_pending);
    endfunction

    function void check_result(logic [DATA_W-1:0] rd, logic irq);
      logic [DATA_W-1:0] want_rd;
      logic              want_irq;
      if (due_read_data.size() == 0) begin
        $error("result with no item outstanding: read_data=%h irq=%b", rd, irq);
        errors++;
        return;
      end
      want_rd  = due_read_data.pop_front();
      want_irq = due_irq.pop_front();
      if (rd !== want_rd) begin
        $error("read_data: expected %h, got %h", want_rd, rd);
        errors++;
      end
      if (irq !== want_irq) begin
        $error("irq: expected %b, got %b", want_irq, irq);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_read_data.size();
    endfunction
  endclass

  bit          clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_PRESCALE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shared pacing controls: no_idle turns off gaps on both sides,
  // hold_off_req asks the receiver for one long stall.
  bit          no_idle;
  bit          hold_off_req;

  timer_shadow shadow = new();

  ptmr_in_if  in_ch();
  ptmr_out_if out_ch();

  prescaled_down_count_timer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Observe both channels and the config port at the rising edge. A result
  // taken at this edge belongs to an earlier item, so the order of the
  // check and the new prediction does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) shadow.set_config(cfg_index, cfg_wdata);
      if (out_ch.valid && out_ch.ready) shadow.check_result(out_ch.read_data, out_ch.irq);
      if (in_ch.valid && in_ch.ready) begin
        shadow.take_item(command_t'(in_ch.command), reg_sel_t'(in_ch.reg_select),
                         in_ch.write_data);
      end
    end
  end

  // Receiver: drop ready at random, or hold it low for a long stretch on
  // request so the single output register fills and input stalls behind it.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  // Offer one item from a falling edge, hold it until taken, then idle a
  // random while. Valid stays high across back-to-back items.
  task automatic send_item(input command_t cmd, input reg_sel_t sel,
                           input logic [DATA_W-1:0] data);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.reg_select <= sel;
    in_ch.write_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    gap = no_idle ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random item biased toward ticks and short reload values so the counter
  // expires often; control writes mostly start, sometimes hold update.
  task automatic send_random_item();
    int                pick;
    command_t          cmd;
    reg_sel_t          sel;
    logic [DATA_W-1:0] data;
    pick = $urandom_range(0, 99);
    data = $urandom;
    sel  = reg_sel_t'($urandom_range(0, 3));
    if (pick < 52) begin
      cmd = CMD_TICK;
    end else if (pick < 67) begin
      cmd = CMD_READ;
    end else if (pick < 95) begin
      cmd = CMD_WRITE;
      if (sel == SEL_CONTROL) begin
        data[BIT_START]  = ($urandom_range(0, 9) != 0);
        data[BIT_UPDATE] = ($urandom_range(0, 7) == 0);
        data[BIT_RELOAD] = ($urandom_range(0, 1) != 0);
      end else if (sel == SEL_BUFFER && $urandom_range(0, 9) != 0) begin
        data = $urandom_range(0, 12);
      end
    end else begin
      cmd = CMD_NONE;
    end
    send_item(cmd, sel, data);
  endtask

  // Drop valid and wait for every owed result, then let the pipe settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (shadow.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (3) @(negedge clk);
  endtask

  // Write both timebase registers; call only with the block idle.
  task automatic set_timebase(input logic [CFG_DATA_W-1:0] prescale,
                              input logic [CFG_DATA_W-1:0] divider);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRESCALE;
    cfg_wdata <= prescale;
    @(negedge clk);
    cfg_index <= CFG_DIVIDER;
    cfg_wdata <= divider;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_READ;
    in_ch.reg_select = SEL_CONTROL;
    in_ch.write_data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset contents, extreme values, manual update, expiry from
    // one and from zero, stop vs. auto-reload, pending clear, ignored writes.
    send_item(CMD_READ,  SEL_CONTROL, '0);
    send_item(CMD_READ,  SEL_BUFFER,  '1);
    send_item(CMD_READ,  SEL_OBSERVE, '0);
    send_item(CMD_READ,  SEL_IRQ,     '1);
    send_item(CMD_WRITE, SEL_IRQ,     IRQ_EN_MASK);
    send_item(CMD_WRITE, SEL_BUFFER,  '1);
    send_item(CMD_WRITE, SEL_CONTROL, '1);          // all bits: load on update
    send_item(CMD_READ,  SEL_CONTROL, '0);          // unused bits read as zero
    send_item(CMD_TICK,  SEL_OBSERVE, '0);          // update held: reload again
    send_item(CMD_WRITE, SEL_OBSERVE, '1);          // observation is read only
    send_item(CMD_NONE,  SEL_IRQ,     '1);          // unused command
    send_item(CMD_WRITE, SEL_BUFFER,  DATA_W'(2));
    send_item(CMD_WRITE, SEL_CONTROL, CTRL_START | CTRL_UPDATE);
    send_item(CMD_WRITE, SEL_CONTROL, CTRL_START);
    send_item(CMD_TICK,  SEL_CONTROL, '0);          // two to one
    send_item(CMD_TICK,  SEL_BUFFER,  '1);          // expire from one and stop
    send_item(CMD_TICK,  SEL_IRQ,     '0);          // stopped: counter holds
    send_item(CMD_READ,  SEL_IRQ,     '0);
    send_item(CMD_READ,  SEL_OBSERVE, '0);
    send_item(CMD_WRITE, SEL_CONTROL, CTRL_START | CTRL_RELOAD);
    send_item(CMD_TICK,  SEL_CONTROL, '0);          // expire from zero, reload
    send_item(CMD_WRITE, SEL_IRQ,     IRQ_EN_MASK | IRQ_PND_MASK);
    send_item(CMD_READ,  SEL_OBSERVE, '0);
    send_item(CMD_WRITE, SEL_IRQ,     '0);
    send_item(CMD_WRITE, SEL_CONTROL, '0);

    // Random phases, each under its own timebase. The slow extreme comes
    // before a fast one so the prescaler is caught above its new limit.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: set_timebase(8'd0, 8'd0);
        1: set_timebase(8'd255, 8'd4);
        2: set_timebase(8'd0, 8'd7);
        3: set_timebase(8'd3, 8'd1);
        4: set_timebase(8'd1, 8'd5);
        default: set_timebase(CFG_DATA_W'($urandom_range(0, 3)),
                              CFG_DATA_W'($urandom_range(0, 3)));
      endcase
      // One phase runs flat out, with a long receiver stall at its start.
      no_idle = (phase == 3);
      if (phase == 3) hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end

    no_idle = 1'b0;
    drain_results();
    if (shadow.outstanding() != 0) begin
      $error("%0d results never arrived", shadow.outstanding());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("tb_prescaled_down_count_timer_top: done, clean");
    end else begin
      $display("tb_prescaled_down_count_timer_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(10_000_000);
    $display("tb_prescaled_down_count_timer_top: done, errors");
    $finish;
  end

endmodule
